/* hdl/bounded_deque_with_search_defines.svh */
// ----------------------------------------------------------------------------
// Deque assertion macros
// Shared concurrent-check macros for the bounded deque block.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BDQS_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BDQS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bdqs_pkg.sv */
// ----------------------------------------------------------------------------
// Deque package
// Sizes, command codes and the cell control word for the bounded deque.
// ----------------------------------------------------------------------------
`default_nettype none

package bdqs_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT    = 3'd0,
    CMD_PUSH_BACK     = 3'd1,
    CMD_POP_FRONT     = 3'd2,
    CMD_POP_BACK      = 3'd3,
    CMD_SEARCH        = 3'd4,
    CMD_SEARCH_REMOVE = 3'd5
  } cmd_e;

  // Broadcast to every cell; push and pop enables are already qualified by full/empty.
  typedef struct packed {
    logic  push_front;   // take left neighbor's word
    logic  pop_front;    // take right neighbor's word
    logic  remove;       // take right word at and after first match
    logic  push_back;    // tail cell loads the key
    word_t key;          // push data / search key
  } ctl_t;

endpackage

`default_nettype wire

/* hdl/bdqs_cell.sv */
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot: compares against the key, ripples the match chain and
// takes its next word from itself, a neighbor or the key.
// ----------------------------------------------------------------------------
`default_nettype none

module bdqs_cell (
  input  logic           clk,
  input  bdqs_pkg::ctl_t ctl,
  input  logic           valid,
  input  logic           tail,
  input  bdqs_pkg::word_t left_word,
  input  bdqs_pkg::word_t right_word,
  input  logic           match_in,
  output bdqs_pkg::word_t word,
  output bdqs_pkg::word_t word_next,
  output logic           match_out
);

  logic hit;

  always_comb begin
    hit       = valid && (word == ctl.key);
    match_out = match_in || hit;
    priority if (ctl.push_front) begin
      word_next = left_word;
    end else if (ctl.pop_front) begin
      word_next = right_word;
    end else if (ctl.remove && match_out) begin
      word_next = right_word;
    end else if (ctl.push_back && tail) begin
      word_next = ctl.key;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

/* hdl/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// Bounded deque with search
// Sixteen-word double-ended queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd/value and raise start; the word is taken at
//   a rising edge with start high and busy low. busy is always low here, so
//   a command may be issued every cycle.
//   Result channel: one status word per command, shown for exactly one cycle
//   with done high, the cycle after the command is taken. It carries found,
//   error, front_value, back_value, entry_count and is_empty, all reflecting
//   the store after the command. The receiver cannot stall; a result not
//   sampled in its done cycle is gone.
//   Throughput 1 command per cycle: every cell compares
//   and shifts in the same cycle, and the first-match chain ripples through
//   the row of cells within that cycle.
//   Push when full / pop when empty: error set, store unchanged.
//   Codes 6 and 7 do nothing and report the unchanged store.
//   Reset (rst, synchronous): count goes to zero, no result pending. Cell
//   contents are not cleared; only occupied slots are ever observed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_deque_with_search_defines.svh"

module bounded_deque_with_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     cmd,
  input  logic [bdqs_pkg::VALUE_W-1:0]   value,
  output logic                           done,
  output logic                           found,
  output logic                           error,
  output logic [bdqs_pkg::VALUE_W-1:0]   front_value,
  output logic [bdqs_pkg::VALUE_W-1:0]   back_value,
  output logic [bdqs_pkg::CNT_W-1:0]     entry_count,
  output logic                           is_empty
);

  // --- state ---
  bdqs_pkg::count_t occupancy;
  bdqs_pkg::count_t occupancy_next;

  // --- cell row wiring ---
  bdqs_pkg::ctl_t  ctl;
  bdqs_pkg::word_t word_q     [bdqs_pkg::DEPTH];
  bdqs_pkg::word_t word_d     [bdqs_pkg::DEPTH];
  bdqs_pkg::word_t left_word  [bdqs_pkg::DEPTH];
  bdqs_pkg::word_t right_word [bdqs_pkg::DEPTH];
  logic [bdqs_pkg::DEPTH-1:0] valid;
  logic [bdqs_pkg::DEPTH-1:0] tail;
  logic [bdqs_pkg::DEPTH-1:0] last_next;
  logic [bdqs_pkg::DEPTH:0]   match;

  logic            accept;
  logic            full;
  logic            empty;
  logic            hit_any;
  logic            found_d;
  logic            error_d;
  bdqs_pkg::word_t back_d;
  bdqs_pkg::word_t front_d;

  // The whole update is combinational ahead of the registers, so the port never blocks.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full    = (occupancy == bdqs_pkg::CNT_W'(bdqs_pkg::DEPTH));
  assign empty   = (occupancy == '0);
  assign hit_any = match[bdqs_pkg::DEPTH];

  // Decode the command into qualified enables for the row.
  always_comb begin
    ctl            = '0;
    ctl.key        = value[bdqs_pkg::DATA_WIDTH-1:0];
    found_d        = 1'b0;
    error_d        = 1'b0;
    occupancy_next = occupancy;
    if (accept) begin
      unique case (cmd)
        bdqs_pkg::CMD_PUSH_FRONT: begin
          error_d        = full;
          ctl.push_front = !full;
          if (!full) occupancy_next = occupancy + 1'b1;
        end
        bdqs_pkg::CMD_PUSH_BACK: begin
          error_d       = full;
          ctl.push_back = !full;
          if (!full) occupancy_next = occupancy + 1'b1;
        end
        bdqs_pkg::CMD_POP_FRONT: begin
          error_d       = empty;
          ctl.pop_front = !empty;
          if (!empty) occupancy_next = occupancy - 1'b1;
        end
        bdqs_pkg::CMD_POP_BACK: begin
          // Dropping the tail is just a count change.
          error_d = empty;
          if (!empty) occupancy_next = occupancy - 1'b1;
        end
        bdqs_pkg::CMD_SEARCH: begin
          found_d = hit_any;
        end
        bdqs_pkg::CMD_SEARCH_REMOVE: begin
          found_d    = hit_any;
          ctl.remove = 1'b1;   // cells only move when the chain is set
          if (hit_any) occupancy_next = occupancy - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Per-slot position flags and neighbor hookup. The key enters from the
  // left on a front push; the last cell sees zero from the right.
  always_comb begin
    for (int i = 0; i < bdqs_pkg::DEPTH; i++) begin
      valid[i]     = (bdqs_pkg::CNT_W'(i) < occupancy);
      tail[i]      = (bdqs_pkg::CNT_W'(i) == occupancy);
      last_next[i] = (bdqs_pkg::CNT_W'(i + 1) == occupancy_next);
      left_word[i]  = (i == 0) ? ctl.key : word_q[(i == 0) ? 0 : i - 1];
      right_word[i] = (i == bdqs_pkg::DEPTH - 1) ? '0
                    : word_q[(i == bdqs_pkg::DEPTH - 1) ? i : i + 1];
    end
  end

  assign match[0] = 1'b0;

  for (genvar g = 0; g < bdqs_pkg::DEPTH; g++) begin : g_cell
    bdqs_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (valid[g]),
      .tail       (tail[g]),
      .left_word  (left_word[g]),
      .right_word (right_word[g]),
      .match_in   (match[g]),
      .word       (word_q[g]),
      .word_next  (word_d[g]),
      .match_out  (match[g+1])
    );
  end

  // Back word: AND-OR over the slot that will be last.
  always_comb begin
    back_d = '0;
    for (int i = 0; i < bdqs_pkg::DEPTH; i++) begin
      back_d = back_d | (word_d[i] & {bdqs_pkg::DATA_WIDTH{last_next[i]}});
    end
    front_d = (occupancy_next != '0) ? word_d[0] : '0;
  end

  // Count, strobe and status register.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy   <= '0;
      done        <= 1'b0;
      entry_count <= '0;
      is_empty    <= 1'b1;
    end else begin
      occupancy   <= occupancy_next;
      done        <= accept;
      entry_count <= occupancy_next;
      is_empty    <= (occupancy_next == '0);
    end
    found       <= found_d;
    error       <= error_d;
    front_value <= bdqs_pkg::VALUE_W'(front_d);
    back_value  <= bdqs_pkg::VALUE_W'(back_d);
  end

  // --- checks ---
  `BDQS_CHECK_NOW(a_found_err_excl, done, !(found && error), "found and error both set")
  `BDQS_CHECK_NOW(a_single_ends, done && (entry_count == bdqs_pkg::CNT_W'(1)), front_value == back_value, "one entry but front and back differ")
  `BDQS_CHECK_NEXT(a_push_back_tail, accept && (cmd == bdqs_pkg::CMD_PUSH_BACK) && !full, back_value == $past(value), "push back did not land at tail")
  `BDQS_CHECK_NOW(a_count_bound, 1'b1, occupancy <= bdqs_pkg::CNT_W'(bdqs_pkg::DEPTH), "occupancy above depth")

endmodule

`default_nettype wire
